[design/pfdr_pkg.sv]
// shared types, command codes and panel byte constants for the page frame store
package pfdr_pkg;

  // command codes
  localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
  localparam logic [2:0] CMD_CLR_PIXEL = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_REFRESH   = 3'd3;
  localparam logic [2:0] CMD_FETCH     = 3'd4;

  // panel command bytes
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_CMD    = 8'h00;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;
  localparam logic [7:0] ALL_PAGES     = 8'hFF;

  // store access request from the control logic
  typedef struct packed {
    logic       valid;    // read the column word
    logic       wr;       // modify and write back the pixel bit
    logic       set;      // set (1) or clear (0) the bit
    logic       clear;    // start a clearing pass
    logic [7:0] col;
    logic [2:0] page;
    logic [2:0] bit_idx;
  } pfdr_store_req_t;

  typedef struct packed {
    logic       active;
    logic [2:0] page;
  } pfdr_pick_t;

  // lowest pending page of a mask
  function automatic pfdr_pick_t pfdr_lowest_page(input logic [7:0] mask);
    pfdr_pick_t r;
    r = '0;
    for (int p = 7; p >= 0; p--) begin
      if (mask[p]) begin
        r.active = 1'b1;
        r.page   = 3'(p);
      end
    end
    return r;
  endfunction

endpackage

[design/pfdr_if.sv]
// valid/ready channels for commands in and refresh bytes out
interface pfdr_cmd_if;
  import pfdr_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] x;
  logic [7:0] y;
  modport source (output valid, output command, output x, output y, input ready);
  modport sink (input valid, input command, input x, input y, output ready);
endinterface

interface pfdr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;
  logic       none_pending;
  modport source (output valid, output out_byte, output is_data, output last,
                  output none_pending, input ready);
  modport sink (input valid, input out_byte, input is_data, input last,
                input none_pending, output ready);
endinterface

[design/pfdr_store.sv]
// column-word pixel memory with read-modify-write, forwarding and clearing pass
module pfdr_store
  import pfdr_pkg::*;
#(
  parameter int WIDTH = 128,
  parameter int PAGES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfdr_store_req_t      req,
  output logic                 busy,
  output logic [8*PAGES-1:0]   word
);

  localparam int COL_W  = $clog2(WIDTH);
  localparam int WORD_W = 8 * PAGES;

  logic [WORD_W-1:0] mem [WIDTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] fwd_data;
  logic              fwd_hit;

  logic              clearing;
  logic [COL_W-1:0]  clr_addr;

  logic              s1_wr;
  logic              s1_set;
  logic [COL_W-1:0]  s1_col;
  logic [2:0]        s1_page;
  logic [2:0]        s1_bit;

  logic              we;
  logic [COL_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] new_word;
  logic [COL_W-1:0]  rcol;

  assign rcol = req.col[COL_W-1:0];
  assign busy = clearing;

  // current word, with the write of the previous cycle forwarded
  assign word = fwd_hit ? fwd_data : rdata;

  // pixel bit update
  always_comb begin
    new_word = word;
    new_word[{s1_page, s1_bit}] = s1_set;
  end

  // write port: clearing pass or pixel write-back
  always_comb begin
    we    = clearing || s1_wr;
    waddr = clearing ? clr_addr : s1_col;
    wdata = clearing ? '0 : new_word;
  end

  // memory array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req.valid) begin
      rdata    <= mem[rcol];
      fwd_data <= wdata;
    end
  end

  // forward hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.valid) begin
      fwd_hit <= we && (waddr == rcol);
    end
  end

  // write-back stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr <= 1'b0;
    end else begin
      s1_wr <= req.valid && req.wr;
    end
    if (req.valid) begin
      s1_set  <= req.set;
      s1_col  <= rcol;
      s1_page <= req.page;
      s1_bit  <= req.bit_idx;
    end
  end

  // clearing pass, one column per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (req.clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == COL_W'(WIDTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

endmodule

[design/page_framebuffer_dirty_refresh.sv]
// Page-organized monochrome frame store with per-page dirty marks. Set pixel, clear pixel,
// begin refresh and fetch commands are taken one per cycle; a fetch's byte reaches the
// response channel through the fetch stage and the output register, as data bytes come from a
// column-word memory with a registered read. Pixel writes are read-modify-write on that
// memory with forwarding, so back-to-back commands on the same column are safe. Clear
// screen, and reset, start a clearing pass over the memory, one column per cycle; no
// command is taken during it. The response channel holds one item in an output register;
// while it is stalled a further fetch waits and stops the command input.
module page_framebuffer_dirty_refresh
  import pfdr_pkg::*;
#(
  parameter int WIDTH = 128,
  parameter int PAGES = 8
) (
  input  logic       clk,
  input  logic       rst,
  pfdr_cmd_if.sink   cmd,
  pfdr_rsp_if.source rsp
);

  localparam logic [8:0] COLS      = 9'(WIDTH);
  localparam logic [8:0] ROWS      = 9'(8 * PAGES);
  localparam logic [8:0] LAST_POS  = 9'(WIDTH + 2);
  localparam logic [7:0] PAGE_ALL  = 8'((1 << PAGES) - 1);

  // refresh control
  logic       first_refresh, first_refresh_next;
  logic [7:0] dirty_pages, dirty_pages_next;
  logic [7:0] refresh_mask, refresh_mask_next;
  logic [2:0] refresh_page, refresh_page_next;
  logic [7:0] byte_position, byte_position_next;
  logic       refresh_active, refresh_active_next;

  // fetch waiting for its memory word
  logic       s1_fetch;
  logic [7:0] s1_byte, s1_byte_next;
  logic       s1_data, s1_data_next;
  logic       s1_last, s1_last_next;
  logic       s1_none, s1_none_next;
  logic [2:0] s1_page;

  // output register
  logic       rsp_valid;
  logic [7:0] rsp_byte;
  logic       rsp_is_data;
  logic       rsp_last;
  logic       rsp_none;

  logic                 busy;
  logic [8*PAGES-1:0]   word;
  pfdr_store_req_t      req;
  logic                 stall;
  logic                 accept;
  logic                 in_range;
  pfdr_pick_t           pick;
  logic [7:0]           merged;
  logic [7:0]           sel_byte;

  pfdr_store #(
    .WIDTH (WIDTH),
    .PAGES (PAGES)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .busy (busy),
    .word (word)
  );

  // handshake
  assign stall     = s1_fetch && rsp_valid && !rsp.ready;
  assign cmd.ready = !busy && !stall;
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = ({1'b0, cmd.x} < COLS) && ({1'b0, cmd.y} < ROWS);

  // command decode and refresh walk
  always_comb begin
    first_refresh_next  = first_refresh;
    dirty_pages_next    = dirty_pages;
    refresh_mask_next   = refresh_mask;
    refresh_page_next   = refresh_page;
    byte_position_next  = byte_position;
    refresh_active_next = refresh_active;
    s1_byte_next        = '0;
    s1_data_next        = 1'b0;
    s1_last_next        = 1'b0;
    s1_none_next        = 1'b1;
    req                 = '0;
    req.page            = cmd.y[5:3];
    req.bit_idx         = cmd.y[2:0];
    req.col             = cmd.x;
    req.set             = (cmd.command == CMD_SET_PIXEL);
    merged              = '0;
    pick                = '0;
    if (accept) begin
      case (cmd.command)
        CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
          if (in_range) begin
            req.valid        = 1'b1;
            req.wr           = 1'b1;
            dirty_pages_next = dirty_pages | (8'b1 << cmd.y[5:3]);
          end
        end
        CMD_CLEAR, CMD_REFRESH: begin
          req.clear = (cmd.command == CMD_CLEAR);
          merged    = (first_refresh || req.clear) ? ALL_PAGES : dirty_pages;
          first_refresh_next  = 1'b0;
          dirty_pages_next    = '0;
          refresh_mask_next   = (refresh_mask | merged) & PAGE_ALL;
          pick                = pfdr_lowest_page(refresh_mask_next);
          refresh_page_next   = pick.page;
          byte_position_next  = '0;
          refresh_active_next = pick.active;
        end
        CMD_FETCH: begin
          if (refresh_active) begin
            case (byte_position)
              8'd0: s1_byte_next = PAGE_CMD_BASE + {5'b0, refresh_page};
              8'd1: s1_byte_next = COL_LO_CMD;
              8'd2: s1_byte_next = COL_HI_CMD;
              default: begin
                s1_data_next = 1'b1;
                req.valid    = 1'b1;
                req.col      = byte_position - 8'd3;
              end
            endcase
            s1_none_next = 1'b0;
            if ({1'b0, byte_position} >= LAST_POS) begin
              refresh_mask_next   = refresh_mask & ~(8'b1 << refresh_page) & PAGE_ALL;
              pick                = pfdr_lowest_page(refresh_mask_next);
              refresh_page_next   = pick.page;
              byte_position_next  = '0;
              refresh_active_next = pick.active;
              s1_last_next        = !pick.active;
              s1_none_next        = !pick.active;
            end else begin
              byte_position_next = byte_position + 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // refresh state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_refresh  <= 1'b1;
      dirty_pages    <= '0;
      refresh_mask   <= '0;
      refresh_page   <= '0;
      byte_position  <= '0;
      refresh_active <= 1'b0;
    end else begin
      first_refresh  <= first_refresh_next;
      dirty_pages    <= dirty_pages_next;
      refresh_mask   <= refresh_mask_next;
      refresh_page   <= refresh_page_next;
      byte_position  <= byte_position_next;
      refresh_active <= refresh_active_next;
    end
  end

  // fetch stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_fetch <= 1'b0;
    end else begin
      s1_fetch <= (accept && cmd.command == CMD_FETCH) || stall;
    end
    if (accept) begin
      s1_byte <= s1_byte_next;
      s1_data <= s1_data_next;
      s1_last <= s1_last_next;
      s1_none <= s1_none_next;
      s1_page <= refresh_page;
    end
  end

  // data byte of the current page out of the column word
  assign sel_byte = word[{s1_page, 3'b000} +: 8];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= s1_fetch || (rsp_valid && !rsp.ready);
    end
    if (s1_fetch && !stall) begin
      rsp_byte    <= s1_data ? sel_byte : s1_byte;
      rsp_is_data <= s1_data;
      rsp_last    <= s1_last;
      rsp_none    <= s1_none;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.out_byte     = rsp_byte;
  assign rsp.is_data      = rsp_is_data;
  assign rsp.last         = rsp_last;
  assign rsp.none_pending = rsp_none;

endmodule

[design/pfdr_checker.sv]
// port-level checks for the page frame store, bound to the top level
module pfdr_checker
  import pfdr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [2:0] cmd_command,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_out_byte,
  input logic       rsp_is_data,
  input logic       rsp_last,
  input logic       rsp_none_pending
);

  // a stalled item holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
    else $error("response item changed while stalled");

  // the final byte of a refresh leaves nothing pending
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_last |-> rsp_none_pending)
    else $error("last byte with refresh still pending");

  // an idle fetch answers with a zero command byte
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_none_pending && !rsp_last |-> rsp_out_byte == 8'h00 && !rsp_is_data)
    else $error("idle fetch carries a byte");

  // clear screen starts a clearing pass that blocks commands
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_command == CMD_CLEAR |=> !cmd_ready)
    else $error("command taken right after clear screen");

endmodule

bind page_framebuffer_dirty_refresh pfdr_checker u_pfdr_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_command      (cmd.command),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_out_byte     (rsp.out_byte),
  .rsp_is_data      (rsp.is_data),
  .rsp_last         (rsp.last),
  .rsp_none_pending (rsp.none_pending)
);
